[rtl/core/fyv_pkg.sv]
// Shared types, constants and CORDIC helpers for the formation yaw velocity controller.
// Depends on nothing; the front end, the CORDIC pipe, the back end and the top level use it.
package fyv_pkg;

   localparam int CORDIC_ITERATIONS = 16;   // 8 .. 24

   localparam int AXW = 40;   // atan2 vector width
   localparam int AZW = 34;   // atan2 angle width, Q30
   localparam int SXW = 34;   // sin/cos vector width, Q30
   localparam int SZW = 36;   // sin/cos angle width, Q30

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Z   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_YAW = 3'd5;

   localparam logic signed [SZW-1:0] PI_Q30      = 36'sd3373259369;
   localparam logic signed [SZW-1:0] HALF_PI_Q30 = 36'sd1686629684;
   localparam logic signed [SXW-1:0] KGAIN_Q30   = 34'sd652032874;
   localparam logic signed [17:0]    PI_Q12      = 18'sd12868;

   typedef struct packed {
      logic signed [16:0] dx;     // setpoint minus measured, Q5.10
      logic signed [16:0] dy;
      logic signed [16:0] dz;
      logic signed [14:0] syaw;   // setpoint yaw, Q3.12
   } ctx_type;

   typedef struct packed {
      logic signed [AXW-1:0] ax;
      logic signed [AXW-1:0] ay;
      logic signed [AZW-1:0] az;
      logic                  zero;   // both atan2 operands zero
      logic signed [SXW-1:0] sx;
      logic signed [SXW-1:0] sy;
      logic signed [SZW-1:0] sz;
      logic                  neg;    // result of sin/cos to be negated
      ctx_type               ctx;
   } cdc_type;

   function automatic logic [31:0] atan_tab(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // One CORDIC micro-rotation of both engines: vectoring (atan2) and rotation (sin/cos).
   function automatic cdc_type cordic_step(input cdc_type a, input logic [4:0] i);
      cdc_type r;
      logic signed [SZW-1:0] t;
      t = $signed({4'b0, atan_tab(i)});
      r = a;
      if (a.ay > 0) begin
         r.ax = a.ax + (a.ay >>> i);
         r.ay = a.ay - (a.ax >>> i);
         r.az = a.az + AZW'(t);
      end else begin
         r.ax = a.ax - (a.ay >>> i);
         r.ay = a.ay + (a.ax >>> i);
         r.az = a.az - AZW'(t);
      end
      if (a.sz >= 0) begin
         r.sx = a.sx - (a.sy >>> i);
         r.sy = a.sy + (a.sx >>> i);
         r.sz = a.sz - t;
      end else begin
         r.sx = a.sx + (a.sy >>> i);
         r.sy = a.sy - (a.sx >>> i);
         r.sz = a.sz + t;
      end
      return r;
   endfunction

endpackage

[rtl/core/fyv_if.sv]
// Valid/ready channel interfaces for the request and response items.
// Depends on nothing.
interface fyv_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] setpoint_x;
   logic signed [15:0] setpoint_y;
   logic signed [15:0] setpoint_z;
   logic signed [14:0] setpoint_yaw;
   logic signed [15:0] meas_x;
   logic signed [15:0] meas_y;
   logic signed [15:0] meas_z;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (output valid, setpoint_x, setpoint_y, setpoint_z, setpoint_yaw,
                   meas_x, meas_y, meas_z, quat_x, quat_y, quat_z, quat_w,
                   input ready);
   modport sink (input valid, setpoint_x, setpoint_y, setpoint_z, setpoint_yaw,
                 meas_x, meas_y, meas_z, quat_x, quat_y, quat_z, quat_w,
                 output ready);
endinterface

interface fyv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] vel_z;
   logic signed [15:0] yaw_rate;

   modport source (output valid, vel_x, vel_y, vel_z, yaw_rate, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, yaw_rate, output ready);
endinterface

[rtl/core/fyv_front.sv]
// Front end: quaternion products, atan2 operands and CORDIC start vectors (two stages).
// Depends on fyv_pkg.
module fyv_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [15:0]     setpoint_x,
   input  logic signed [15:0]     setpoint_y,
   input  logic signed [15:0]     setpoint_z,
   input  logic signed [14:0]     setpoint_yaw,
   input  logic signed [15:0]     meas_x,
   input  logic signed [15:0]     meas_y,
   input  logic signed [15:0]     meas_z,
   input  logic signed [15:0]     quat_x,
   input  logic signed [15:0]     quat_y,
   input  logic signed [15:0]     quat_z,
   input  logic signed [15:0]     quat_w,
   output logic                   out_valid,
   output fyv_pkg::cdc_type       out_data
);

   logic               v1_ff;
   logic signed [31:0] p_zw_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   fyv_pkg::ctx_type   ctx1_ff, ctx1_in;

   logic               v2_ff;
   fyv_pkg::cdc_type   st2_ff, st2_in;

   logic signed [32:0] sum_a, sum_b;
   logic signed [33:0] num;
   logic signed [34:0] den;
   logic signed [fyv_pkg::SZW-1:0] zin;

   always_comb begin
      ctx1_in.dx   = 17'(setpoint_x) - 17'(meas_x);
      ctx1_in.dy   = 17'(setpoint_y) - 17'(meas_y);
      ctx1_in.dz   = 17'(setpoint_z) - 17'(meas_z);
      ctx1_in.syaw = setpoint_yaw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         p_zw_ff <= 32'(quat_z) * 32'(quat_w);
         p_xy_ff <= 32'(quat_x) * 32'(quat_y);
         p_yy_ff <= 32'(quat_y) * 32'(quat_y);
         p_zz_ff <= 32'(quat_z) * 32'(quat_z);
         ctx1_ff <= ctx1_in;
      end
   end

   always_comb begin
      sum_a = 33'(p_zw_ff) + 33'(p_xy_ff);
      sum_b = 33'(p_yy_ff) + 33'(p_zz_ff);
      num   = 34'(sum_a) <<< 1;
      den   = 35'sd268435456 - (35'(sum_b) <<< 1);

      st2_in      = '0;
      st2_in.ctx  = ctx1_ff;
      st2_in.zero = (num == 0) && (den == 0);
      if (den < 0) begin
         if (num >= 0) begin
            st2_in.ax = fyv_pkg::AXW'(num);
            st2_in.ay = -fyv_pkg::AXW'(den);
            st2_in.az = fyv_pkg::AZW'(fyv_pkg::HALF_PI_Q30);
         end else begin
            st2_in.ax = -fyv_pkg::AXW'(num);
            st2_in.ay = fyv_pkg::AXW'(den);
            st2_in.az = -fyv_pkg::AZW'(fyv_pkg::HALF_PI_Q30);
         end
      end else begin
         st2_in.ax = fyv_pkg::AXW'(den);
         st2_in.ay = fyv_pkg::AXW'(num);
         st2_in.az = '0;
      end

      // leader yaw to Q30, folded into +-pi/2
      zin = fyv_pkg::SZW'(ctx1_ff.syaw) <<< 18;
      st2_in.sx = fyv_pkg::KGAIN_Q30;
      st2_in.sy = '0;
      if (zin > fyv_pkg::HALF_PI_Q30) begin
         st2_in.sz  = zin - fyv_pkg::PI_Q30;
         st2_in.neg = 1'b1;
      end else if (zin < -fyv_pkg::HALF_PI_Q30) begin
         st2_in.sz  = zin + fyv_pkg::PI_Q30;
         st2_in.neg = 1'b1;
      end else begin
         st2_in.sz  = zin;
         st2_in.neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         st2_ff <= st2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = st2_ff;

endmodule

[rtl/core/fyv_cordic_pipe.sv]
// Unrolled CORDIC: one register stage per iteration, atan2 and sin/cos side by side.
// Depends on fyv_pkg.
module fyv_cordic_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  fyv_pkg::cdc_type in_data,
   output logic             out_valid,
   output fyv_pkg::cdc_type out_data
);

   localparam int N = fyv_pkg::CORDIC_ITERATIONS;

   logic             v_ff  [N];
   fyv_pkg::cdc_type st_ff [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_iter
         logic             v_prev;
         fyv_pkg::cdc_type st_prev;
         if (g == 0) begin : g_first
            assign v_prev  = in_valid;
            assign st_prev = in_data;
         end else begin : g_next
            assign v_prev  = v_ff[g-1];
            assign st_prev = st_ff[g-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (adv) begin
               v_ff[g] <= v_prev;
            end
            if (adv) begin
               st_ff[g] <= fyv_pkg::cordic_step(st_prev, 5'(g));
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[N-1];
   assign out_data  = st_ff[N-1];

endmodule

[rtl/core/fyv_back.sv]
// Back end: offset rotation, error forming, gain products and saturation (five stages).
// Depends on fyv_pkg; the last stage is the response register.
module fyv_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  fyv_pkg::cdc_type   in_data,
   input  logic signed [15:0] offset_x,
   input  logic signed [15:0] offset_y,
   input  logic [11:0]        gain_x,
   input  logic [11:0]        gain_y,
   input  logic [11:0]        gain_z,
   input  logic [11:0]        gain_yaw,
   output logic               out_valid,
   output logic signed [15:0] vel_x,
   output logic signed [15:0] vel_y,
   output logic signed [15:0] vel_z,
   output logic signed [15:0] yaw_rate
);

   // stage 1: sign fix of sin/cos, vehicle yaw to Q3.12
   logic               v1_ff;
   logic signed [34:0] c_ff, c_in, s_ff, s_in;
   logic signed [15:0] yaw_ff, yaw_in;
   fyv_pkg::ctx_type   ctx1_ff;
   logic signed [fyv_pkg::AZW-1:0] zr;
   logic signed [34:0] zs;

   always_comb begin
      zr     = in_data.zero ? '0 : in_data.az;
      zs     = 35'(zr) + 35'sd131072;
      yaw_in = 16'(zs >>> 18);
      c_in   = in_data.neg ? -35'(in_data.sx) : 35'(in_data.sx);
      s_in   = in_data.neg ? -35'(in_data.sy) : 35'(in_data.sy);
   end

   // stage 2: rotation products, wrapped yaw error
   logic               v2_ff;
   logic signed [50:0] cox_ff, soy_ff, coy_ff, sox_ff;
   logic signed [17:0] eyaw_ff, eyaw_in;
   fyv_pkg::ctx_type   ctx2_ff;
   logic signed [17:0] ed;

   always_comb begin
      ed = 18'(ctx1_ff.syaw) - 18'(yaw_ff);
      if (ed > fyv_pkg::PI_Q12) begin
         eyaw_in = ed - (fyv_pkg::PI_Q12 <<< 1);
      end else if (ed < -fyv_pkg::PI_Q12) begin
         eyaw_in = ed + (fyv_pkg::PI_Q12 <<< 1);
      end else begin
         eyaw_in = ed;
      end
   end

   // stage 3: rotated offset rounded to Q5.10, position errors
   logic               v3_ff;
   logic signed [23:0] ex_ff, ex_in, ey_ff, ey_in, ez_ff;
   logic signed [17:0] eyaw3_ff;
   logic signed [51:0] lxs, lys;
   logic signed [21:0] lx, ly;

   always_comb begin
      lxs   = 52'(cox_ff) + 52'(soy_ff) + 52'sd536870912;
      lys   = 52'(coy_ff) - 52'(sox_ff) + 52'sd536870912;
      lx    = 22'(lxs >>> 30);
      ly    = 22'(lys >>> 30);
      ex_in = 24'(ctx2_ff.dx) - 24'(lx);
      ey_in = 24'(ctx2_ff.dy) - 24'(ly);
   end

   // stage 4: gain products
   logic               v4_ff;
   logic signed [36:0] px_ff, py_ff, pz_ff, pyaw_ff;

   // stage 5: round and saturate into the response register
   logic               v5_ff;
   logic signed [15:0] vx_ff, vy_ff, vz_ff, vyaw_ff;

   function automatic logic signed [15:0] rnd_sat(input logic signed [36:0] p);
      logic signed [36:0] r;
      r = (p + 37'sd128) >>> 8;
      if (r > 37'sd32767) begin
         return 16'sh7FFF;
      end else if (r < -37'sd32768) begin
         return 16'sh8000;
      end
      return 16'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (adv) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         yaw_ff   <= yaw_in;
         ctx1_ff  <= in_data.ctx;

         cox_ff   <= 51'(c_ff) * 51'(offset_x);
         soy_ff   <= 51'(s_ff) * 51'(offset_y);
         coy_ff   <= 51'(c_ff) * 51'(offset_y);
         sox_ff   <= 51'(s_ff) * 51'(offset_x);
         eyaw_ff  <= eyaw_in;
         ctx2_ff  <= ctx1_ff;

         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         ez_ff    <= 24'(ctx2_ff.dz);
         eyaw3_ff <= eyaw_ff;

         px_ff    <= 37'(ex_ff) * 37'($signed({1'b0, gain_x}));
         py_ff    <= 37'(ey_ff) * 37'($signed({1'b0, gain_y}));
         pz_ff    <= 37'(ez_ff) * 37'($signed({1'b0, gain_z}));
         pyaw_ff  <= 37'(eyaw3_ff) * 37'($signed({1'b0, gain_yaw}));

         vx_ff    <= rnd_sat(px_ff);
         vy_ff    <= rnd_sat(py_ff);
         vz_ff    <= rnd_sat(pz_ff);
         vyaw_ff  <= rnd_sat(pyaw_ff);
      end
   end

   assign out_valid = v5_ff;
   assign vel_x     = vx_ff;
   assign vel_y     = vy_ff;
   assign vel_z     = vz_ff;
   assign yaw_rate  = vyaw_ff;

endmodule

[rtl/core/formation_yaw_p_velocity_controller_unit.sv]
// Top level of the formation yaw / position velocity controller.
// Depends on fyv_pkg, fyv_if, fyv_front, fyv_cordic_pipe and fyv_back.
//
//   channel | direction | handshake       | content
//   req     | in        | valid / ready   | setpoints, measured position, quaternion
//   rsp     | out       | valid / ready   | vel_x, vel_y, vel_z, yaw_rate
//   csr     | in        | csr_we          | offsets and gains, index 0 .. 5
//
// Items pass through the front-end stages, the unrolled CORDIC stages and the back-end
// stages; one item can enter every cycle while no response waits untaken.
// Reset clears the valid bits and loads the register defaults.
// The whole pipe moves as one: it halts only while a response waits untaken,
// so a stall neither drops nor repeats an item.
module formation_yaw_p_velocity_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   fyv_req_if.sink                             req,
   fyv_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [fyv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fyv_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic signed [15:0] offset_x_ff, offset_y_ff;
   logic [11:0]        gain_x_ff, gain_y_ff, gain_z_ff, gain_yaw_ff;

   // configuration writes; unknown indices are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= 16'sd0;
         offset_y_ff <= -16'sd512;
         gain_x_ff   <= 12'd384;
         gain_y_ff   <= 12'd384;
         gain_z_ff   <= 12'd384;
         gain_yaw_ff <= 12'd256;
      end else if (csr_we) begin
         case (csr_index)
            fyv_pkg::CSR_OFFSET_X: offset_x_ff <= $signed(csr_wdata);
            fyv_pkg::CSR_OFFSET_Y: offset_y_ff <= $signed(csr_wdata);
            fyv_pkg::CSR_GAIN_X:   gain_x_ff   <= csr_wdata[11:0];
            fyv_pkg::CSR_GAIN_Y:   gain_y_ff   <= csr_wdata[11:0];
            fyv_pkg::CSR_GAIN_Z:   gain_z_ff   <= csr_wdata[11:0];
            fyv_pkg::CSR_GAIN_YAW: gain_yaw_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // the pipe advances whenever the response register is free or being emptied
   logic adv;
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   logic             f_valid, c_valid;
   fyv_pkg::cdc_type f_data, c_data;

   fyv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req.valid),
      .setpoint_x   (req.setpoint_x),
      .setpoint_y   (req.setpoint_y),
      .setpoint_z   (req.setpoint_z),
      .setpoint_yaw (req.setpoint_yaw),
      .meas_x       (req.meas_x),
      .meas_y       (req.meas_y),
      .meas_z       (req.meas_z),
      .quat_x       (req.quat_x),
      .quat_y       (req.quat_y),
      .quat_z       (req.quat_z),
      .quat_w       (req.quat_w),
      .out_valid    (f_valid),
      .out_data     (f_data)
   );

   fyv_cordic_pipe u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (c_valid),
      .out_data  (c_data)
   );

   fyv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (c_valid),
      .in_data   (c_data),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .gain_x    (gain_x_ff),
      .gain_y    (gain_y_ff),
      .gain_z    (gain_z_ff),
      .gain_yaw  (gain_yaw_ff),
      .out_valid (rsp.valid),
      .vel_x     (rsp.vel_x),
      .vel_y     (rsp.vel_y),
      .vel_z     (rsp.vel_z),
      .yaw_rate  (rsp.yaw_rate)
   );

endmodule

[dv/tb_fyv_pkg.sv]
`timescale 1ns / 1ps
// Testbench-side types for the formation yaw velocity controller bench.
// Depends on nothing; the interfaces come from the RTL file fyv_if.sv.
package tb_fyv_pkg;

   typedef struct packed {
      logic signed [15:0] setpoint_x;
      logic signed [15:0] setpoint_y;
      logic signed [15:0] setpoint_z;
      logic signed [14:0] setpoint_yaw;
      logic signed [15:0] meas_x;
      logic signed [15:0] meas_y;
      logic signed [15:0] meas_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } tick_type;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
      logic signed [15:0] yaw_rate;
   } cmd_type;

endpackage

[dv/tb_formation_yaw_p_velocity_controller_unit.sv]
`timescale 1ns / 1ps
// Top-level bench for formation_yaw_p_velocity_controller_unit: random and directed ticks,
// an in-bench predictor of the velocity commands, and a scoreboard on the response channel.
// Depends on fyv_pkg, fyv_if (RTL) and tb_fyv_pkg.
module tb_formation_yaw_p_velocity_controller_unit;

   localparam int NITER    = fyv_pkg::CORDIC_ITERATIONS;
   localparam int LATENCY  = 2 + NITER + 5;
   localparam longint PIQ30  = 64'sd3373259369;
   localparam longint HPIQ30 = 64'sd1686629684;
   localparam longint KQ30   = 64'sd652032874;
   localparam longint PIQ12  = 64'sd12868;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we    = 1'b0;
   logic [fyv_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fyv_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   fyv_req_if req ();
   fyv_rsp_if rsp ();

   formation_yaw_p_velocity_controller_unit u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the register file
   longint off_x, off_y, g_x, g_y, g_z, g_yaw;
   tb_fyv_pkg::cmd_type cmd_q[$];
   int     n_err = 0;
   bit     rsp_stall_on = 1'b1;

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_sh(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint atan_q30(int i);
      longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      return t[i];
   endfunction

   // vehicle heading, Q30, by vectoring CORDIC
   function automatic longint heading_q30(longint num, longint den);
      longint x, y, z, t;
      z = 0;
      if (num == 0 && den == 0) return 0;
      if (den < 0) begin
         if (num >= 0) begin x = num; y = -den; z = HPIQ30; end
         else begin x = -num; y = den; z = -HPIQ30; end
      end else begin
         x = den; y = num;
      end
      for (int i = 0; i < NITER; i++) begin
         if (y > 0) begin
            t = x + asr(y, i); y = y - asr(x, i); x = t; z += atan_q30(i);
         end else begin
            t = x - asr(y, i); y = y + asr(x, i); x = t; z -= atan_q30(i);
         end
      end
      return z;
   endfunction

   function automatic tb_fyv_pkg::cmd_type velocity_cmd(tb_fyv_pkg::tick_type k);
      longint num, den, yaw, x, y, z, t, lx, ly, ex, ey, ez, eyaw;
      bit neg;
      tb_fyv_pkg::cmd_type r;
      num = 2 * (longint'(k.quat_z) * k.quat_w + longint'(k.quat_x) * k.quat_y);
      den = (64'sd1 <<< 28) - 2 * (longint'(k.quat_y) * k.quat_y
                                   + longint'(k.quat_z) * k.quat_z);
      yaw = rnd_sh(heading_q30(num, den), 18);
      // leader-yaw rotation of the formation offset
      z = longint'(k.setpoint_yaw) * 262144;
      x = KQ30; y = 0; neg = 0;
      if (z > HPIQ30) begin z -= PIQ30; neg = 1; end
      else if (z < -HPIQ30) begin z += PIQ30; neg = 1; end
      for (int i = 0; i < NITER; i++) begin
         if (z >= 0) begin
            t = x - asr(y, i); y = y + asr(x, i); x = t; z -= atan_q30(i);
         end else begin
            t = x + asr(y, i); y = y - asr(x, i); x = t; z += atan_q30(i);
         end
      end
      if (neg) begin x = -x; y = -y; end
      lx = rnd_sh(x * off_x + y * off_y, 30);
      ly = rnd_sh(x * off_y - y * off_x, 30);
      ex = longint'(k.setpoint_x) - k.meas_x - lx;
      ey = longint'(k.setpoint_y) - k.meas_y - ly;
      ez = longint'(k.setpoint_z) - k.meas_z;
      eyaw = longint'(k.setpoint_yaw) - yaw;
      if (eyaw > PIQ12) eyaw -= 2 * PIQ12;
      else if (eyaw < -PIQ12) eyaw += 2 * PIQ12;
      r.vel_x    = 16'(sat16(rnd_sh(g_x * ex, 8)));
      r.vel_y    = 16'(sat16(rnd_sh(g_y * ey, 8)));
      r.vel_z    = 16'(sat16(rnd_sh(g_z * ez, 8)));
      r.yaw_rate = 16'(sat16(rnd_sh(g_yaw * eyaw, 8)));
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      req.valid = 1'b0;
      req.setpoint_x = '0; req.setpoint_y = '0; req.setpoint_z = '0;
      req.setpoint_yaw = '0; req.meas_x = '0; req.meas_y = '0; req.meas_z = '0;
      req.quat_x = '0; req.quat_y = '0; req.quat_z = '0; req.quat_w = '0;
      rsp.ready = 1'b0;
   end

   // one item onto the request channel; prediction taken at acceptance.
   // valid stays high after acceptance; a gap or drain() lowers it
   task automatic send_tick(tb_fyv_pkg::tick_type k);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.setpoint_x   <= k.setpoint_x;   req.setpoint_y <= k.setpoint_y;
      req.setpoint_z   <= k.setpoint_z;   req.setpoint_yaw <= k.setpoint_yaw;
      req.meas_x       <= k.meas_x;       req.meas_y <= k.meas_y;
      req.meas_z       <= k.meas_z;
      req.quat_x       <= k.quat_x;       req.quat_y <= k.quat_y;
      req.quat_z       <= k.quat_z;       req.quat_w <= k.quat_w;
      do @(posedge clock); while (!req.ready);
      cmd_q.push_back(velocity_cmd(k));
   endtask

   task automatic csr_write(logic [fyv_pkg::CSR_IDX_W-1:0] idx, longint v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         fyv_pkg::CSR_OFFSET_X: off_x = longint'($signed(16'(v)));
         fyv_pkg::CSR_OFFSET_Y: off_y = longint'($signed(16'(v)));
         fyv_pkg::CSR_GAIN_X:   g_x   = v & 12'hFFF;
         fyv_pkg::CSR_GAIN_Y:   g_y   = v & 12'hFFF;
         fyv_pkg::CSR_GAIN_Z:   g_z   = v & 12'hFFF;
         fyv_pkg::CSR_GAIN_YAW: g_yaw = v & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (cmd_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_regs(longint ox, longint oy, longint gx, longint gy,
                           longint gz, longint gw);
      drain();
      csr_write(fyv_pkg::CSR_OFFSET_X, ox);
      csr_write(fyv_pkg::CSR_OFFSET_Y, oy);
      csr_write(fyv_pkg::CSR_GAIN_X, gx);
      csr_write(fyv_pkg::CSR_GAIN_Y, gy);
      csr_write(fyv_pkg::CSR_GAIN_Z, gz);
      csr_write(fyv_pkg::CSR_GAIN_YAW, gw);
   endtask

   function automatic tb_fyv_pkg::tick_type rand_tick();
      tb_fyv_pkg::tick_type k;
      k.setpoint_x = 16'($urandom); k.setpoint_y = 16'($urandom);
      k.setpoint_z = 16'($urandom);
      k.setpoint_yaw = 15'($signed($urandom_range(0, 25736)) - 12868);
      k.meas_x = 16'($urandom); k.meas_y = 16'($urandom); k.meas_z = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         // raw quaternion bits, out of range included
         k.quat_x = 16'($urandom); k.quat_y = 16'($urandom);
         k.quat_z = 16'($urandom); k.quat_w = 16'($urandom);
      end else begin
         k.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
         k.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
         k.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
         k.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
      end
      // small errors half the time so the outputs do not always saturate
      if ($urandom_range(0, 1)) begin
         k.meas_x = 16'(k.setpoint_x + $signed($urandom_range(0, 4000)) - 2000);
         k.meas_y = 16'(k.setpoint_y + $signed($urandom_range(0, 4000)) - 2000);
         k.meas_z = 16'(k.setpoint_z + $signed($urandom_range(0, 4000)) - 2000);
      end
      return k;
   endfunction

   function automatic tb_fyv_pkg::tick_type base_tick();
      tb_fyv_pkg::tick_type k;
      k = '0;
      k.quat_w = 16'sd16384;
      return k;
   endfunction

   // ---- tests ----
   task automatic test_directed();
      tb_fyv_pkg::tick_type k;
      send_tick(base_tick());                       // level, at rest
      k = base_tick(); k.setpoint_x = 16'sh7FFF; k.meas_x = 16'sh8000;
      k.setpoint_y = 16'sh8000; k.meas_y = 16'sh7FFF;
      k.setpoint_z = 16'sh7FFF; k.meas_z = 16'sh8000;
      send_tick(k);                                 // saturate all position axes
      k = base_tick(); k.setpoint_yaw = 15'sd12868; send_tick(k);   // +pi
      k = base_tick(); k.setpoint_yaw = -15'sd12868; send_tick(k);  // -pi
      k = base_tick(); k.setpoint_yaw = 15'sh3FFF; send_tick(k);    // beyond pi
      k = base_tick(); k.setpoint_yaw = 15'sh4000; send_tick(k);
      k = '0; send_tick(k);                          // zero quaternion
      k = '0; k.quat_z = 16'sd16384; k.setpoint_yaw = -15'sd12000;
      send_tick(k);                                 // heading pi, wrap
      k = '0; k.quat_z = 16'sd16384; k.quat_w = -16'sd16384; send_tick(k);
      k = '0; k.quat_x = 16'sh7FFF; k.quat_y = 16'sh8000; k.quat_z = 16'sh7FFF;
      k.quat_w = 16'sh8000; send_tick(k);          // far from unit norm
      k = '0; k.quat_y = 16'sd16384; send_tick(k);  // den negative, num zero
      k = '0; k.quat_z = 16'sd11585; k.quat_w = -16'sd11585; send_tick(k);
      k = base_tick(); k.setpoint_yaw = 15'sd6434; send_tick(k);    // pi/2
      k = base_tick(); k.setpoint_yaw = -15'sd6434; send_tick(k);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_tick(rand_tick());
   endtask

   task automatic test_reg_extremes();
      set_regs(-32768, 32767, 4095, 4095, 4095, 4095);
      test_directed();
      test_random(100);
      set_regs(32767, -32768, 0, 0, 0, 0);
      test_random(50);
      set_regs(0, 0, 1, 4095, 0, 1);
      test_random(50);
      drain();
      csr_write(3'd6, 16'hFFFF);                    // unmapped index, ignored
      csr_write(3'd7, 16'h1234);
      test_random(50);
   endtask

   task automatic test_random_regs(int phases, int n);
      for (int p = 0; p < phases; p++) begin
         set_regs(longint'($signed(16'($urandom))), longint'($signed(16'($urandom))),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
         rsp_stall_on = (p % 3 != 2);               // some phases with no stall
         test_random(n);
      end
      rsp_stall_on = 1'b1;
   endtask

   // response side: random ready, scoreboard
   always @(posedge clock) begin
      tb_fyv_pkg::cmd_type got, want;
      if (!reset) begin
         rsp.ready <= rsp_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.vel_x, rsp.vel_y, rsp.vel_z, rsp.yaw_rate};
            if (cmd_q.size() == 0) begin
               n_err++;
               $display("%0t: unexpected response %h", $time, got);
            end else begin
               want = cmd_q.pop_front();
               if (got.vel_x != want.vel_x)
                  $display("%0t: vel_x exp %0d got %0d", $time, want.vel_x, got.vel_x);
               if (got.vel_y != want.vel_y)
                  $display("%0t: vel_y exp %0d got %0d", $time, want.vel_y, got.vel_y);
               if (got.vel_z != want.vel_z)
                  $display("%0t: vel_z exp %0d got %0d", $time, want.vel_z, got.vel_z);
               if (got.yaw_rate != want.yaw_rate)
                  $display("%0t: yaw_rate exp %0d got %0d", $time, want.yaw_rate,
                           got.yaw_rate);
               if (got != want) n_err++;
            end
         end
      end
   end

   initial begin
      off_x = 0; off_y = -512; g_x = 384; g_y = 384; g_z = 384; g_yaw = 256;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();                              // reset defaults
      test_random(330);
      test_reg_extremes();
      test_random_regs(8, 80);
      drain();
      if (n_err == 0 && cmd_q.size() == 0)
         $display("tb_formation_yaw_p_velocity_controller_unit: clean");
      else
         $display("tb_formation_yaw_p_velocity_controller_unit: errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_formation_yaw_p_velocity_controller_unit: errors");
      $finish;
   end

endmodule

[sim.f]
rtl/core/fyv_pkg.sv
rtl/core/fyv_if.sv
rtl/core/fyv_front.sv
rtl/core/fyv_cordic_pipe.sv
rtl/core/fyv_back.sv
rtl/core/formation_yaw_p_velocity_controller_unit.sv
dv/tb_fyv_pkg.sv
dv/tb_formation_yaw_p_velocity_controller_unit.sv
